FILE: rtl/azel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// azel_pkg
// Shared constants, types and the arctangent table for the azimuth and
// elevation pipeline.
// ----------------------------------------------------------------------------
package azel_pkg;

   // CORDIC iteration count (12 to 32)
   localparam int CORDIC_STAGES = 20;
   // one restoring square-root step per stage, one result bit from two input bits each
   localparam int SQRT_STAGES   = 32;
   localparam int GEOM_LAT      = 7;
   localparam int CORDIC_LAT    = CORDIC_STAGES + 1;
   localparam int TOTAL_LAT     = GEOM_LAT + SQRT_STAGES + CORDIC_LAT + 1;

   localparam int ANGLE_W       = 26;

   localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE_FINE = 26'sd5898240;
   localparam logic signed [18:0]        FULL_TURN        = 19'sd92160;
   localparam logic signed [18:0]        ELEV_LIMIT       = 19'sd23040;

   // sideband that travels with a transaction through the square root
   typedef struct packed {
      logic               zero;
      logic signed [48:0] ax;
      logic signed [51:0] ay;
      logic signed [34:0] v;
   } azel_side_type;

   // geometry front end result
   typedef struct packed {
      logic          valid;
      azel_side_type side;
      logic [63:0]   h2;
   } azel_geom_type;

   // atan(2^-i) in 1/65536 degree, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] atan_fine(input int i);
      logic signed [ANGLE_W-1:0] a;
      unique case (i)
         0:  a = 26'sd2949120;
         1:  a = 26'sd1740967;
         2:  a = 26'sd919879;
         3:  a = 26'sd466945;
         4:  a = 26'sd234379;
         5:  a = 26'sd117304;
         6:  a = 26'sd58666;
         7:  a = 26'sd29335;
         8:  a = 26'sd14668;
         9:  a = 26'sd7334;
         10: a = 26'sd3667;
         11: a = 26'sd1833;
         12: a = 26'sd917;
         13: a = 26'sd458;
         14: a = 26'sd229;
         15: a = 26'sd115;
         16: a = 26'sd57;
         17: a = 26'sd29;
         18: a = 26'sd14;
         19: a = 26'sd7;
         20: a = 26'sd4;
         21: a = 26'sd2;
         22: a = 26'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/azel_geom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// azel_geom
// Seven-stage front end: direction, normalization, right axis, dot products
// and the squared horizontal component for the square root.
// ----------------------------------------------------------------------------
module azel_geom (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic signed [31:0]   origin_x,
   input  wire logic signed [31:0]   origin_y,
   input  wire logic signed [31:0]   origin_z,
   input  wire logic signed [15:0]   view_x,
   input  wire logic signed [15:0]   view_y,
   input  wire logic signed [15:0]   view_z,
   input  wire logic signed [15:0]   up_x,
   input  wire logic signed [15:0]   up_y,
   input  wire logic signed [15:0]   up_z,
   input  wire logic signed [31:0]   target_x,
   input  wire logic signed [31:0]   target_y,
   input  wire logic signed [31:0]   target_z,
   output azel_pkg::azel_geom_type   geom
);

   logic [6:0] valid_ff;

   // stage 1
   logic [32:0]        mag1_ff [3];
   logic [2:0]         neg1_ff;
   logic               zero1_ff;
   logic signed [31:0] p1_ff [6];
   logic signed [15:0] vw1_ff [3];
   logic signed [15:0] up1_ff [3];
   // stage 2
   logic [32:0]        mag2_ff [3];
   logic [2:0]         neg2_ff;
   logic               zero2_ff;
   logic [32:0]        mx2_ff;
   logic signed [32:0] rt2_ff [3];
   logic signed [15:0] vw2_ff [3];
   logic signed [15:0] up2_ff [3];
   // stage 3
   logic signed [16:0] d3_ff [3];
   logic               zero3_ff;
   logic signed [32:0] rt3_ff [3];
   logic signed [15:0] vw3_ff [3];
   logic signed [15:0] up3_ff [3];
   // stage 4
   logic signed [32:0] pv4_ff [3];
   logic signed [49:0] pr4_ff [3];
   logic signed [32:0] pu4_ff [3];
   logic signed [33:0] pd4_ff [3];
   logic               zero4_ff;
   // stage 5
   logic signed [34:0] ax5_ff;
   logic signed [51:0] ay5_ff;
   logic signed [34:0] v5_ff;
   logic signed [35:0] dd5_ff;
   logic               zero5_ff;
   // stage 6
   logic signed [48:0] ax6_ff;
   logic signed [51:0] ay6_ff;
   logic signed [34:0] v6_ff;
   logic [63:0]        vv6_ff;
   logic [63:0]        ddsh6_ff;
   logic               big6_ff;
   logic               zero6_ff;
   // stage 7
   azel_pkg::azel_side_type side7_ff;
   logic [63:0]             h27_ff;

   logic signed [32:0] d_in [3];
   logic [32:0]        mx_in;
   logic [4:0]         s_in;
   logic [32:0]        sh_in [3];
   logic [34:0]        av_in;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   // stage 1: direction, magnitudes, cross-product terms
   always_comb begin
      d_in[0] = $signed({target_x[31], target_x}) - $signed({origin_x[31], origin_x});
      d_in[1] = $signed({target_y[31], target_y}) - $signed({origin_y[31], origin_y});
      d_in[2] = $signed({target_z[31], target_z}) - $signed({origin_z[31], origin_z});
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         neg1_ff[k] <= d_in[k][32];
         mag1_ff[k] <= d_in[k][32] ? 33'(-d_in[k]) : 33'(d_in[k]);
      end
      zero1_ff <= (d_in[0] == '0) && (d_in[1] == '0) && (d_in[2] == '0);
      p1_ff[0] <= view_z * up_y;
      p1_ff[1] <= view_y * up_z;
      p1_ff[2] <= view_x * up_z;
      p1_ff[3] <= view_z * up_x;
      p1_ff[4] <= view_y * up_x;
      p1_ff[5] <= view_x * up_y;
      vw1_ff[0] <= view_x;
      vw1_ff[1] <= view_y;
      vw1_ff[2] <= view_z;
      up1_ff[0] <= up_x;
      up1_ff[1] <= up_y;
      up1_ff[2] <= up_z;
   end

   // stage 2: largest magnitude, right axis
   always_comb begin
      mx_in = mag1_ff[0];
      if (mag1_ff[1] > mx_in) mx_in = mag1_ff[1];
      if (mag1_ff[2] > mx_in) mx_in = mag1_ff[2];
   end

   always_ff @(posedge clock) begin
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      zero2_ff <= zero1_ff;
      mx2_ff   <= mx_in;
      rt2_ff[0] <= $signed({p1_ff[0][31], p1_ff[0]}) - $signed({p1_ff[1][31], p1_ff[1]});
      rt2_ff[1] <= $signed({p1_ff[2][31], p1_ff[2]}) - $signed({p1_ff[3][31], p1_ff[3]});
      rt2_ff[2] <= $signed({p1_ff[4][31], p1_ff[4]}) - $signed({p1_ff[5][31], p1_ff[5]});
      vw2_ff <= vw1_ff;
      up2_ff <= up1_ff;
   end

   // stage 3: common shift so the largest component is below 2^16
   always_comb begin
      s_in = '0;
      for (int j = 16; j < 33; j++) begin
         if (mx2_ff[j]) s_in = 5'(j - 15);
      end
      for (int k = 0; k < 3; k++) begin
         sh_in[k] = mag2_ff[k] >> s_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         d3_ff[k] <= neg2_ff[k] ? -$signed({1'b0, sh_in[k][15:0]})
                                :  $signed({1'b0, sh_in[k][15:0]});
      end
      zero3_ff <= zero2_ff;
      rt3_ff   <= rt2_ff;
      vw3_ff   <= vw2_ff;
      up3_ff   <= up2_ff;
   end

   // stage 4: products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         pv4_ff[k] <= d3_ff[k] * vw3_ff[k];
         pr4_ff[k] <= d3_ff[k] * rt3_ff[k];
         pu4_ff[k] <= d3_ff[k] * up3_ff[k];
         pd4_ff[k] <= d3_ff[k] * d3_ff[k];
      end
      zero4_ff <= zero3_ff;
   end

   // stage 5: dot products
   always_ff @(posedge clock) begin
      ax5_ff <= 35'(pv4_ff[0]) + 35'(pv4_ff[1]) + 35'(pv4_ff[2]);
      ay5_ff <= 52'(pr4_ff[0]) + 52'(pr4_ff[1]) + 52'(pr4_ff[2]);
      v5_ff  <= 35'(pu4_ff[0]) + 35'(pu4_ff[1]) + 35'(pu4_ff[2]);
      dd5_ff <= 36'(pd4_ff[0]) + 36'(pd4_ff[1]) + 36'(pd4_ff[2]);
      zero5_ff <= zero4_ff;
   end

   // stage 6: square of the vertical part, scaled length
   assign av_in = v5_ff[34] ? 35'(-v5_ff) : 35'(v5_ff);

   always_ff @(posedge clock) begin
      ax6_ff   <= {ax5_ff, 14'b0};
      ay6_ff   <= ay5_ff;
      v6_ff    <= v5_ff;
      vv6_ff   <= av_in[31:0] * av_in[31:0];
      big6_ff  <= |av_in[34:32];
      ddsh6_ff <= {dd5_ff[35:0], 28'b0};
      zero6_ff <= zero5_ff;
   end

   // stage 7: squared horizontal part, zero when the vertical square reaches the scaled length
   always_ff @(posedge clock) begin
      side7_ff.zero <= zero6_ff;
      side7_ff.ax   <= ax6_ff;
      side7_ff.ay   <= ay6_ff;
      side7_ff.v    <= v6_ff;
      h27_ff <= (!big6_ff && (ddsh6_ff > vv6_ff)) ? ddsh6_ff - vv6_ff : '0;
   end

   assign geom.valid = valid_ff[6];
   assign geom.side  = side7_ff;
   assign geom.h2    = h27_ff;

endmodule
`default_nettype wire

FILE: rtl/azel_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// azel_sqrt
// Pipelined restoring integer square root, one result bit per stage, with
// the transaction sideband carried alongside.
// ----------------------------------------------------------------------------
module azel_sqrt (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire azel_pkg::azel_geom_type geom,
   output logic                         out_valid,
   output azel_pkg::azel_side_type      out_side,
   output logic [31:0]                  out_root
);

   localparam int N = azel_pkg::SQRT_STAGES;

   logic                    src_valid [N];
   logic [63:0]             src_n     [N];
   logic [63:0]             src_root  [N];
   azel_pkg::azel_side_type src_side  [N];

   logic                    valid_ff [N];
   logic [63:0]             n_ff     [N];
   logic [63:0]             root_ff  [N];
   azel_pkg::azel_side_type side_ff  [N];

   assign src_valid[0] = geom.valid;
   assign src_n[0]     = geom.h2;
   assign src_root[0]  = '0;
   assign src_side[0]  = geom.side;

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] trial;

      if (i > 0) begin : g_link
         assign src_valid[i] = valid_ff[i-1];
         assign src_n[i]     = n_ff[i-1];
         assign src_root[i]  = root_ff[i-1];
         assign src_side[i]  = side_ff[i-1];
      end

      assign trial = src_root[i] + BIT;

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= src_valid[i];
         end
      end

      // one restoring step
      always_ff @(posedge clock) begin
         side_ff[i] <= src_side[i];
         if (src_n[i] >= trial) begin
            n_ff[i]    <= src_n[i] - trial;
            root_ff[i] <= (src_root[i] >> 1) + BIT;
         end else begin
            n_ff[i]    <= src_n[i];
            root_ff[i] <= src_root[i] >> 1;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_root  = root_ff[N-1][31:0];

endmodule
`default_nettype wire

FILE: rtl/azel_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// azel_cordic
// Pipelined CORDIC vectoring unit: atan2(y, x) in 1/65536 degree, one
// quadrant fold stage then one iteration per stage.
// ----------------------------------------------------------------------------
module azel_cordic (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  op_valid,
   input  wire logic signed [63:0]                    op_x,
   input  wire logic signed [63:0]                    op_y,
   output logic                                       res_valid,
   output logic signed [azel_pkg::ANGLE_W-1:0]        res_angle
);

   localparam int N = azel_pkg::CORDIC_STAGES;

   // fold stage
   logic                                pv_ff;
   logic                                pz0_ff;
   logic signed [63:0]                  px_ff;
   logic signed [63:0]                  py_ff;
   logic signed [azel_pkg::ANGLE_W-1:0] pa_ff;

   logic                                src_valid [N];
   logic                                src_zero  [N];
   logic signed [63:0]                  src_x     [N];
   logic signed [63:0]                  src_y     [N];
   logic signed [azel_pkg::ANGLE_W-1:0] src_a     [N];

   logic                                valid_ff [N];
   logic                                zero_ff  [N];
   logic signed [63:0]                  x_ff     [N];
   logic signed [63:0]                  y_ff     [N];
   logic signed [azel_pkg::ANGLE_W-1:0] a_ff     [N];

   // fold left half-plane onto the right
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      pz0_ff <= (op_x == '0) && (op_y == '0);
      if (op_x[63] && !op_y[63]) begin
         px_ff <= op_y;
         py_ff <= -op_x;
         pa_ff <= azel_pkg::RIGHT_ANGLE_FINE;
      end else if (op_x[63]) begin
         px_ff <= -op_y;
         py_ff <= op_x;
         pa_ff <= -azel_pkg::RIGHT_ANGLE_FINE;
      end else begin
         px_ff <= op_x;
         py_ff <= op_y;
         pa_ff <= '0;
      end
   end

   assign src_valid[0] = pv_ff;
   assign src_zero[0]  = pz0_ff;
   assign src_x[0]     = px_ff;
   assign src_y[0]     = py_ff;
   assign src_a[0]     = pa_ff;

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [azel_pkg::ANGLE_W-1:0] ATAN = azel_pkg::atan_fine(i);
      logic signed [63:0] xs;
      logic signed [63:0] ys;

      if (i > 0) begin : g_link
         assign src_valid[i] = valid_ff[i-1];
         assign src_zero[i]  = zero_ff[i-1];
         assign src_x[i]     = x_ff[i-1];
         assign src_y[i]     = y_ff[i-1];
         assign src_a[i]     = a_ff[i-1];
      end

      assign xs = src_x[i] >>> i;
      assign ys = src_y[i] >>> i;

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= src_valid[i];
         end
      end

      // micro-rotation toward y = 0
      always_ff @(posedge clock) begin
         zero_ff[i] <= src_zero[i];
         if (!src_y[i][63]) begin
            x_ff[i] <= src_x[i] + ys;
            y_ff[i] <= src_y[i] - xs;
            a_ff[i] <= src_a[i] + ATAN;
         end else begin
            x_ff[i] <= src_x[i] - ys;
            y_ff[i] <= src_y[i] + xs;
            a_ff[i] <= src_a[i] - ATAN;
         end
      end
   end

   assign res_valid = valid_ff[N-1];
   assign res_angle = zero_ff[N-1] ? '0 : a_ff[N-1];

endmodule
`default_nettype wire

FILE: rtl/azimuth_elevation_to_target_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// azimuth_elevation_to_target_unit
// Listener-relative azimuth and elevation of a target position.
// ----------------------------------------------------------------------------
// Pipeline: 7 geometry stages, 32 square root stages, 21 CORDIC stages and
// one output stage between start and rsp_valid.
// Throughput: one transaction per cycle; busy stays low, the pipeline never
// stalls since the receiver cannot hold results off.
// Reset: synchronous, clears the valid bits; data registers are not reset.
module azimuth_elevation_to_target_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [31:0]  req_origin_x,
   input  wire logic signed [31:0]  req_origin_y,
   input  wire logic signed [31:0]  req_origin_z,
   input  wire logic signed [15:0]  req_view_x,
   input  wire logic signed [15:0]  req_view_y,
   input  wire logic signed [15:0]  req_view_z,
   input  wire logic signed [15:0]  req_up_x,
   input  wire logic signed [15:0]  req_up_y,
   input  wire logic signed [15:0]  req_up_z,
   input  wire logic signed [31:0]  req_target_x,
   input  wire logic signed [31:0]  req_target_y,
   input  wire logic signed [31:0]  req_target_z,
   output logic                     rsp_valid,
   output logic [16:0]              rsp_azimuth,
   output logic signed [15:0]       rsp_elevation,
   output logic                     rsp_zero_direction
);

   localparam int ZL = azel_pkg::CORDIC_LAT;

   azel_pkg::azel_geom_type geom;
   logic                    sq_valid;
   azel_pkg::azel_side_type sq_side;
   logic [31:0]             sq_root;

   logic                                az_valid;
   logic signed [azel_pkg::ANGLE_W-1:0] az_angle;
   logic                                el_valid;
   logic signed [azel_pkg::ANGLE_W-1:0] el_angle;

   logic [ZL-1:0] zero_ff;

   logic                 valid_ff;
   logic [16:0]          azimuth_ff;
   logic signed [15:0]   elevation_ff;
   logic                 zdir_ff;

   logic signed [azel_pkg::ANGLE_W-1:0] az_rnd;
   logic signed [azel_pkg::ANGLE_W-1:0] el_rnd;
   logic signed [18:0]                  az_in;
   logic signed [18:0]                  el_in;

   assign busy = 1'b0;

   azel_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .origin_x (req_origin_x),
      .origin_y (req_origin_y),
      .origin_z (req_origin_z),
      .view_x   (req_view_x),
      .view_y   (req_view_y),
      .view_z   (req_view_z),
      .up_x     (req_up_x),
      .up_y     (req_up_y),
      .up_z     (req_up_z),
      .target_x (req_target_x),
      .target_y (req_target_y),
      .target_z (req_target_z),
      .geom     (geom)
   );

   azel_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   azel_cordic u_az_cordic (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (sq_valid),
      .op_x      (64'(sq_side.ax)),
      .op_y      (64'(sq_side.ay)),
      .res_valid (az_valid),
      .res_angle (az_angle)
   );

   azel_cordic u_el_cordic (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (sq_valid),
      .op_x      ($signed({32'b0, sq_root})),
      .op_y      (64'(sq_side.v)),
      .res_valid (el_valid),
      .res_angle (el_angle)
   );

   // zero-direction flag delayed to match the CORDIC
   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[ZL-2:0], sq_side.zero};
   end

   // round to 1/256 degree, wrap azimuth, clamp elevation
   always_comb begin
      az_rnd = (az_angle + 26'sd128) >>> 8;
      el_rnd = (el_angle + 26'sd128) >>> 8;
      az_in  = 19'(az_rnd);
      el_in  = 19'(el_rnd);
      if (az_in < 0) az_in = az_in + azel_pkg::FULL_TURN;
      if (az_in >= azel_pkg::FULL_TURN) az_in = az_in - azel_pkg::FULL_TURN;
      if (az_in < 0) az_in = '0;
      if (el_in > azel_pkg::ELEV_LIMIT) el_in = azel_pkg::ELEV_LIMIT;
      if (el_in < -azel_pkg::ELEV_LIMIT) el_in = -azel_pkg::ELEV_LIMIT;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= az_valid;
      end
   end

   always_ff @(posedge clock) begin
      zdir_ff <= zero_ff[ZL-1];
      if (zero_ff[ZL-1]) begin
         azimuth_ff   <= '0;
         elevation_ff <= '0;
      end else begin
         azimuth_ff   <= az_in[16:0];
         elevation_ff <= el_in[15:0];
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_azimuth        = azimuth_ff;
   assign rsp_elevation      = elevation_ff;
   assign rsp_zero_direction = zdir_ff;

   // both CORDIC units stay in step
   a_cordic_lockstep : assert property (@(posedge clock) disable iff (reset)
      az_valid == el_valid)
      else $error("azimuth and elevation CORDIC out of step");

   // every result comes from a transaction accepted a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, azel_pkg::TOTAL_LAT))
      else $error("result without matching transaction");

   // zero direction gives zero angles
   a_zero_angles : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_direction) |-> (rsp_azimuth == '0 && rsp_elevation == '0))
      else $error("zero direction with nonzero angles");

   // results stay in range
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_azimuth < 17'd92160 && rsp_elevation <= 16'sd23040
                     && rsp_elevation >= -16'sd23040))
      else $error("angle out of range");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Azimuth / elevation unit testbench
// Drives position and axis transactions through the pipeline with random
// gaps, predicts untyped angle pairs with a bit-accurate CORDIC model and
// checks every strobed result in order against the queue of expected angles.
// ----------------------------------------------------------------------------
module tb;

   localparam int N_RANDOM  = 2000;
   localparam int WDOG_MAX  = 2000;
   localparam int DRAIN_CYC = azel_pkg::TOTAL_LAT + 20;
   localparam longint FULL_TURN_STEPS = 92160;
   localparam longint ELEV_MAX_STEPS  = 23040;
   localparam longint RIGHT_FINE      = 5898240;

   typedef struct {
      logic signed [31:0] org [3];
      logic signed [15:0] vw  [3];
      logic signed [15:0] up  [3];
      logic signed [31:0] tgt [3];
   } geom_query_type;

   typedef struct {
      logic [16:0]        az;
      logic signed [15:0] el;
      logic               zero;
   } angle_pair_type;

   // directed row: query plus optional typed-in answer
   typedef struct {
      geom_query_type q;
      bit             has_ans;
      angle_pair_type ans;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [15:0] req_view_x = '0, req_view_y = '0, req_view_z = '0;
   logic signed [15:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic               rsp_valid;
   logic [16:0]        rsp_azimuth;
   logic signed [15:0] rsp_elevation;
   logic               rsp_zero_direction;

   angle_pair_type expected_angles [$];
   int  mismatches = 0;
   int  idle_cycles = 0;

   azimuth_elevation_to_target_unit DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor arithmetic
   // ------------------------------------------------------------------------
   function automatic longint floor_shift(longint x, int s);
      return x >>> s;
   endfunction

   function automatic longint fine_atan(int i);
      longint tbl [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                           58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                           229, 115, 57, 29, 14, 7, 4, 2, 1};
      return (i < 23) ? tbl[i] : 0;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(root);
   endfunction

   // vectoring CORDIC, angle in 1/65536 degree
   function automatic longint vector_angle(longint x, longint y);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = RIGHT_FINE;
         end else begin
            x = -y; y = t; z = -RIGHT_FINE;
         end
      end
      for (int i = 0; i < azel_pkg::CORDIC_STAGES && i < 32; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += fine_atan(i);
         end else begin
            x -= ys; y += xs; z -= fine_atan(i);
         end
      end
      return z;
   endfunction

   function automatic angle_pair_type predict_angles(geom_query_type q);
      angle_pair_type res;
      longint d [3], vw [3], up [3], rt [3], mag [3];
      longint mx, ax, ay, az, v, el;
      longint unsigned dd, av, h2;
      int s;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         d[k]  = longint'(q.tgt[k]) - longint'(q.org[k]);
         vw[k] = q.vw[k];
         up[k] = q.up[k];
      end
      res.zero = 1'b0;
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
         res.az = '0; res.el = '0; res.zero = 1'b1;
         return res;
      end
      // common shift so the largest magnitude fits in 16 bits
      for (int k = 0; k < 3; k++) mag[k] = (d[k] < 0) ? -d[k] : d[k];
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
      while ((mx >> s) >= 65536) s++;
      for (int k = 0; k < 3; k++) d[k] = (d[k] < 0) ? -(mag[k] >> s) : (mag[k] >> s);
      rt[0] = vw[2] * up[1] - vw[1] * up[2];
      rt[1] = vw[0] * up[2] - vw[2] * up[0];
      rt[2] = vw[1] * up[0] - vw[0] * up[1];
      // azimuth
      ax = (d[0] * vw[0] + d[1] * vw[1] + d[2] * vw[2]) * 16384;
      ay = d[0] * rt[0] + d[1] * rt[1] + d[2] * rt[2];
      az = floor_shift(vector_angle(ax, ay) + 128, 8);
      if (az < 0) az += FULL_TURN_STEPS;
      if (az >= FULL_TURN_STEPS) az -= FULL_TURN_STEPS;
      if (az < 0) az = 0;
      res.az = az[16:0];
      // elevation
      v  = d[0] * up[0] + d[1] * up[1] + d[2] * up[2];
      dd = longint'(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]) << 28;
      av = (v < 0) ? -v : v;
      h2 = 0;
      if (av < (64'd1 << 32)) begin
         if (dd > av * av) h2 = dd - av * av;
      end
      el = floor_shift(vector_angle(int_sqrt(h2), v) + 128, 8);
      if (el > ELEV_MAX_STEPS) el = ELEV_MAX_STEPS;
      if (el < -ELEV_MAX_STEPS) el = -ELEV_MAX_STEPS;
      res.el = el[15:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic geom_query_type make_query(
         longint ox, longint oy, longint oz, int vx, int vy, int vz,
         int ux, int uy, int uz, longint tx, longint ty, longint tz);
      geom_query_type q;
      q.org = '{ox[31:0], oy[31:0], oz[31:0]};
      q.vw  = '{vx[15:0], vy[15:0], vz[15:0]};
      q.up  = '{ux[15:0], uy[15:0], uz[15:0]};
      q.tgt = '{tx[31:0], ty[31:0], tz[31:0]};
      return q;
   endfunction

   function automatic int rand_axis_comp();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return int'($urandom_range(0, 65535)) - 32768;
         2, 3: return 0;
         4, 5: return $urandom_range(0, 1) ? 16384 : -16384;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   function automatic longint rand_pos();
      case ($urandom_range(0, 7))
         0: return longint'($signed($urandom()));
         1: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
         2: return longint'(int'($urandom_range(0, 200))) - 100;
         default: return longint'(int'($urandom_range(0, 2000000))) - 1000000;
      endcase
   endfunction

   function automatic geom_query_type random_query();
      geom_query_type q;
      int pick;
      pick = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         q.org[k] = 32'(rand_pos());
         q.tgt[k] = (pick == 0) ? q.org[k] : 32'(rand_pos());
         q.vw[k]  = 16'(rand_axis_comp());
         q.up[k]  = 16'(rand_axis_comp());
      end
      // mostly orthonormal frames: permuted, signed basis axes
      if (pick >= 3) begin
         int a, b;
         a = $urandom_range(0, 2);
         b = (a + $urandom_range(1, 2)) % 3;
         for (int k = 0; k < 3; k++) begin
            q.vw[k] = '0;
            q.up[k] = '0;
         end
         q.vw[a] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         q.up[b] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      end
      return q;
   endfunction

   task automatic send_query(geom_query_type q);
      start        <= 1'b1;
      req_origin_x <= q.org[0]; req_origin_y <= q.org[1]; req_origin_z <= q.org[2];
      req_view_x   <= q.vw[0];  req_view_y   <= q.vw[1];  req_view_z   <= q.vw[2];
      req_up_x     <= q.up[0];  req_up_y     <= q.up[1];  req_up_z     <= q.up[2];
      req_target_x <= q.tgt[0]; req_target_y <= q.tgt[1]; req_target_z <= q.tgt[2];
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: n = 0;
         9: n = $urandom_range(10, 80);
         default: n = $urandom_range(1, 3);
      endcase
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         angle_pair_type e;
         if (expected_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result az=%0d el=%0d zero=%0b",
                                           rsp_azimuth, rsp_elevation, rsp_zero_direction);
         end else begin
            e = expected_angles.pop_front();
            if (rsp_azimuth !== e.az || rsp_elevation !== e.el
                || rsp_zero_direction !== e.zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp az=%0d el=%0d zero=%0b got az=%0d el=%0d zero=%0b",
                           e.az, e.el, e.zero, rsp_azimuth, rsp_elevation,
                           rsp_zero_direction);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      dir_row_type rows [$];
      dir_row_type r;
      geom_query_type q;
      int drain;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; answers typed in for the zero-direction cases only
      r.has_ans = 1'b1;
      r.ans = '{az: '0, el: '0, zero: 1'b1};
      r.q = make_query(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0, 0, 0);
      rows.push_back(r);
      r.q = make_query(-2147483648, 2147483647, -1, -32768, 32767, 0, 32767, -32768, 0,
                       -2147483648, 2147483647, -1);
      rows.push_back(r);
      r.has_ans = 1'b0;
      // front, right, behind, left, up, down in a standard frame
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 0, 0, -65536); rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 65536, 0, 0);  rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 0, 0, 65536);  rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, -65536, 0, 0); rows.push_back(r);
      // along up: both azimuth operands zero
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 0, 65536, 0);  rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 0, -65536, 0); rows.push_back(r);
      // degenerate view and up
      r.q = make_query(5, 6, 7, 16384, 0, 0, 16384, 0, 0, 100, -3, 9);   rows.push_back(r);
      r.q = make_query(1, 2, 3, 0, 0, 0, 0, 0, 0, 9, 8, 7);               rows.push_back(r);
      // non-unit up saturates elevation
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 32767, 0, 1, 1000, 0);   rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, -32768, 0, 1, -1000, 0); rows.push_back(r);
      // extreme differences, 33-bit direction
      r.q = make_query(-2147483648, -2147483648, -2147483648, -32768, -32768, -32768,
                       32767, 32767, 32767, 2147483647, 2147483647, 2147483647);
      rows.push_back(r);
      r.q = make_query(2147483647, -2147483648, 0, 32767, -32768, 32767,
                       -32768, 32767, -32768, -2147483648, 2147483647, 1);
      rows.push_back(r);
      // near 360 wrap: just left of straight ahead
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, -1, 0, -2147483647);
      rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, -1, 0, -65536); rows.push_back(r);
      r.q = make_query(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 1, 0, 0);       rows.push_back(r);

      foreach (rows[i]) begin
         if (rows[i].has_ans) begin
            expected_angles.push_back(rows[i].ans);
         end else begin
            expected_angles.push_back(predict_angles(rows[i].q));
         end
         send_query(rows[i].q);
         idle_gap();
      end

      // random part with gaps of varying length
      for (int i = 0; i < N_RANDOM; i++) begin
         q = random_query();
         expected_angles.push_back(predict_angles(q));
         send_query(q);
         if (i % 400 < 300) idle_gap();
      end
      start <= 1'b0;

      while (expected_angles.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYC) begin
         @(posedge clock);
         drain++;
      end

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/azel_pkg.sv
rtl/azel_geom.sv
rtl/azel_sqrt.sv
rtl/azel_cordic.sv
rtl/azimuth_elevation_to_target_unit.sv
sim/tb.sv
